FILE: sv/flbmh_pkg.sv
// Package for the four-lane byte mix hash: lane table words, folds, reset values
// and the controller-to-datapath command bundle.
// No dependencies.
package flbmh_pkg;

  localparam int unsigned LANES    = 4;
  localparam int unsigned CHAR_W   = 9;
  localparam int unsigned WORD_W   = 32;

  // Character pattern that marks empty input; it always restarts the running values.
  localparam logic [CHAR_W-1:0] EMPTY_MARK = 9'h080;

  // floor(sqrt(p) * 1e6) for the primes 2,17,41,59 / 7,31,67,19 / 83,11,47,71 / 5,23,53,41
  localparam logic [WORD_W-1:0] TABLE_WORDS [16] = '{
    32'd1414213, 32'd4123105, 32'd6403124, 32'd7681145,
    32'd2645751, 32'd5567764, 32'd8185352, 32'd4358898,
    32'd9110433, 32'd3316624, 32'd6855654, 32'd8426149,
    32'd2236067, 32'd4795831, 32'd7280109, 32'd6403124
  };

  localparam logic [WORD_W-1:0] LANE_RESET [LANES] = '{32'd1, 32'd2, 32'd3, 32'd4};

  typedef struct packed {
    logic load;    // transaction accepted: latch character, update sum and product
    logic mix;     // update total and lanes 0..2
    logic finish;  // update lane 3 and load the output register
  } flbmh_cmd_t;

  function automatic logic [WORD_W-1:0] table_word(input logic [1:0] lane,
                                                    input logic [1:0] sel);
    return TABLE_WORDS[{lane, sel}];
  endfunction

  function automatic logic [WORD_W-1:0] fold_word(input logic [1:0] lane);
    return TABLE_WORDS[{lane, 2'd0}] ^ TABLE_WORDS[{lane, 2'd1}]
         ^ TABLE_WORDS[{lane, 2'd2}] ^ TABLE_WORDS[{lane, 2'd3}];
  endfunction

  // One lane step: ((lane ^ m) * T[lane row, m & 3]) ^ fold of the row.
  function automatic logic [WORD_W-1:0] mix_lane(input logic [WORD_W-1:0] lane_val,
                                                  input logic [WORD_W-1:0] m,
                                                  input logic [1:0] lane);
    logic [WORD_W-1:0] prod;
    prod = (lane_val ^ m) * table_word(lane, m[1:0]);
    return prod ^ fold_word(lane);
  endfunction

endpackage

FILE: sv/flbmh_if.sv
// Valid/ready channel interfaces for the character input and the lane output.
// Depends on flbmh_pkg for field widths.
interface flbmh_in_if
  import flbmh_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [CHAR_W-1:0] character;
  logic                     word_start;

  modport source (output valid, output character, output word_start, input ready);
  modport sink   (input valid, input character, input word_start, output ready);
endinterface

interface flbmh_out_if
  import flbmh_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] lane_zero;
  logic signed [WORD_W-1:0] lane_one;
  logic signed [WORD_W-1:0] lane_two;
  logic signed [WORD_W-1:0] lane_three;

  modport source (output valid, output lane_zero, output lane_one, output lane_two,
                  output lane_three, input ready);
  modport sink   (input valid, input lane_zero, input lane_one, input lane_two,
                  input lane_three, output ready);
endinterface

FILE: sv/flbmh_ctrl.sv
// Controller: three-step sequencer per transaction and output valid flag.
// Depends on flbmh_pkg (command bundle).
module flbmh_ctrl
  import flbmh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output flbmh_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MIX    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.load   = in_valid && in_ready;
    cmd.mix    = (state == ST_MIX);
    cmd.finish = (state == ST_FINISH) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (cmd.load) state_next = ST_MIX;
      ST_MIX:    state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_load_to_mix: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_MIX)
    else $error("accepted transaction did not enter mix step");

  a_mix_to_finish: assert property (@(posedge clk) disable iff (rst)
    state == ST_MIX |=> state == ST_FINISH)
    else $error("mix step not followed by finish step");

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid && state == ST_IDLE)
    else $error("finish did not present a result");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.mix && !cmd.finish)
    else $error("load overlaps an item in progress");

endmodule

FILE: sv/flbmh_dp.sv
// Datapath: running sum/product/total, four hash lanes and the output register.
// Depends on flbmh_pkg (tables, mix function, command bundle).
module flbmh_dp
  import flbmh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  flbmh_cmd_t               cmd,
  input  logic signed [CHAR_W-1:0] character,
  input  logic                     word_start,
  output logic signed [WORD_W-1:0] lane_zero,
  output logic signed [WORD_W-1:0] lane_one,
  output logic signed [WORD_W-1:0] lane_two,
  output logic signed [WORD_W-1:0] lane_three
);

  logic [WORD_W-1:0] c_in;
  logic              restart_in;
  logic [WORD_W-1:0] c_q;
  logic              restart_q;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] total;
  logic [WORD_W-1:0] lane [LANES];
  logic [WORD_W-1:0] lane3_next;

  assign c_in       = {{(WORD_W-CHAR_W){character[CHAR_W-1]}}, character};
  assign restart_in = word_start || (character == EMPTY_MARK);
  assign lane3_next = mix_lane(lane[3], total, 2'd3);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_q       <= c_in;
      restart_q <= restart_in;
    end
    if (cmd.finish) begin
      lane_zero  <= lane[0];
      lane_one   <= lane[1];
      lane_two   <= lane[2];
      lane_three <= lane3_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      prod  <= 32'd1;
      total <= '0;
      for (int i = 0; i < LANES; i++) lane[i] <= LANE_RESET[i];
    end else begin
      if (cmd.load) begin
        sum  <= (restart_in ? '0 : sum) + c_in;
        prod <= (restart_in ? 32'd1 : prod) * c_in;
      end
      if (cmd.mix) begin
        // sum and prod already hold this item's values
        total   <= (restart_q ? '0 : total) + sum + prod;
        lane[0] <= mix_lane(lane[0], c_q, 2'd0);
        lane[1] <= mix_lane(lane[1], sum, 2'd1);
        lane[2] <= mix_lane(lane[2], prod, 2'd2);
      end
      if (cmd.finish) begin
        lane[3] <= lane3_next;
      end
    end
  end

endmodule

FILE: sv/four_lane_byte_mix_hash.sv
// Four-lane byte mix hash, top level: controller plus datapath.
// Each accepted character goes through the mix step and then the finish step, which loads
// the output register; a new character is accepted only in the idle step, as the running
// product multiply is followed by the dependent lane multiplies.
// Holds in the finish step while the output register is full and not taken.
// Synchronous active-high reset: lanes 1,2,3,4, sum 0, product 1, total 0, output empty.
// Depends on flbmh_pkg, flbmh_if, flbmh_ctrl, flbmh_dp.
module four_lane_byte_mix_hash
  import flbmh_pkg::*;
(
  input logic         clk,
  input logic         rst,
  flbmh_in_if.sink    in_ch,
  flbmh_out_if.source out_ch
);

  flbmh_cmd_t cmd;

  flbmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  flbmh_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .character  (in_ch.character),
    .word_start (in_ch.word_start),
    .lane_zero  (out_ch.lane_zero),
    .lane_one   (out_ch.lane_one),
    .lane_two   (out_ch.lane_two),
    .lane_three (out_ch.lane_three)
  );

endmodule

FILE: tb/sv/testbench.sv
// Testbench for four_lane_byte_mix_hash: directed table, then random words and noise.
// Each transaction is predicted in place and every lane result checked against it.
// Depends on flbmh_pkg, flbmh_if and the four_lane_byte_mix_hash RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import flbmh_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 1500;
  localparam int unsigned DIRECTED_N     = 21;
  localparam int unsigned TAIL_CYCLES    = 20;

  typedef struct packed {
    logic [WORD_W-1:0] lane_zero;
    logic [WORD_W-1:0] lane_one;
    logic [WORD_W-1:0] lane_two;
    logic [WORD_W-1:0] lane_three;
  } lane_set_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              ws;
    logic              pinned;
    lane_set_t         lanes;
  } directed_row_t;

  logic clk;
  logic rst;

  flbmh_in_if  in_bus ();
  flbmh_out_if out_bus ();

  four_lane_byte_mix_hash DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus.sink),
    .out_ch (out_bus.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state
  logic [WORD_W-1:0] lane_st [LANES];
  logic [WORD_W-1:0] word_sum;
  logic [WORD_W-1:0] word_prod;
  logic [WORD_W-1:0] word_total;

  lane_set_t   lanes_due [$];
  lane_set_t   pinned_lanes [int];
  int unsigned chars_taken;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned chars_sent;
  int unsigned rx_stall_left;
  int unsigned rx_cycle;
  logic        rx_steady;

  // First row is the state right after reset with a zero character: every mix value is 0.
  directed_row_t directed_rows [DIRECTED_N] = '{
    '{9'h000, 1'b1, 1'b1, '{
        32'd4123105 ^ 32'd6403124 ^ 32'd7681145,
        (32'd2 * 32'd2645751) ^ 32'd2645751 ^ 32'd5567764 ^ 32'd8185352 ^ 32'd4358898,
        (32'd3 * 32'd9110433) ^ 32'd9110433 ^ 32'd3316624 ^ 32'd6855654 ^ 32'd8426149,
        (32'd4 * 32'd2236067) ^ 32'd2236067 ^ 32'd4795831 ^ 32'd7280109 ^ 32'd6403124}},
    '{9'h07F, 1'b0, 1'b0, '0},  // largest in-range character
    '{9'h180, 1'b0, 1'b0, '0},  // -128
    '{9'h080, 1'b0, 1'b0, '0},  // empty mark without word start
    '{9'h080, 1'b1, 1'b0, '0},
    '{9'h0FF, 1'b1, 1'b0, '0},  // out of range, 255
    '{9'h100, 1'b0, 1'b0, '0},  // out of range, -256
    '{9'h1FF, 1'b0, 1'b0, '0},  // negative mix values, low-bit selects 3, 2 and 1
    '{9'h1FE, 1'b0, 1'b0, '0},
    '{9'h1FD, 1'b0, 1'b0, '0},
    '{9'h001, 1'b1, 1'b0, '0},
    '{9'h002, 1'b0, 1'b0, '0},
    '{9'h003, 1'b0, 1'b0, '0},
    '{9'h041, 1'b1, 1'b0, '0},
    '{9'h062, 1'b0, 1'b0, '0},
    '{9'h063, 1'b0, 1'b0, '0},
    '{9'h080, 1'b0, 1'b0, '0},  // empty mark in mid-word
    '{9'h07A, 1'b0, 1'b0, '0},
    '{9'h000, 1'b0, 1'b0, '0},  // zero product
    '{9'h05A, 1'b1, 1'b0, '0},
    '{9'h17F, 1'b0, 1'b0, '0}   // out of range, -129
  };

  function automatic logic [WORD_W-1:0] lane_step(input logic [WORD_W-1:0] cur,
                                                   input logic [WORD_W-1:0] mval,
                                                   input int unsigned row);
    logic [WORD_W-1:0] row_fold;
    logic [WORD_W-1:0] scaled;
    row_fold = TABLE_WORDS[4*row] ^ TABLE_WORDS[4*row+1]
             ^ TABLE_WORDS[4*row+2] ^ TABLE_WORDS[4*row+3];
    scaled = (cur ^ mval) * TABLE_WORDS[4*row + mval[1:0]];
    return scaled ^ row_fold;
  endfunction

  function automatic lane_set_t absorb_char(input logic [CHAR_W-1:0] raw, input logic ws);
    logic [WORD_W-1:0] c;
    lane_set_t         res;
    c = {{(WORD_W-CHAR_W){raw[CHAR_W-1]}}, raw};
    if (ws || raw == EMPTY_MARK) begin
      word_sum   = '0;
      word_prod  = 32'd1;
      word_total = '0;
    end
    word_sum   = word_sum + c;
    word_prod  = word_prod * c;
    word_total = word_total + word_sum + word_prod;
    lane_st[0] = lane_step(lane_st[0], c, 0);
    lane_st[1] = lane_step(lane_st[1], word_sum, 1);
    lane_st[2] = lane_step(lane_st[2], word_prod, 2);
    lane_st[3] = lane_step(lane_st[3], word_total, 3);
    res.lane_zero  = lane_st[0];
    res.lane_one   = lane_st[1];
    res.lane_two   = lane_st[2];
    res.lane_three = lane_st[3];
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return CHAR_W'($urandom_range(126, 32));
    if (r < 90) return CHAR_W'($urandom_range(255, 0) - 128);
    if (r < 95) return EMPTY_MARK;
    return CHAR_W'($urandom());
  endfunction

  task automatic check_lane(input string name, input logic [WORD_W-1:0] want,
                            input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Transaction stays up until taken; the task returns at the next falling edge, where the caller replaces or drops it.
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic ws);
    in_bus.character  <= ch;
    in_bus.word_start <= ws;
    in_bus.valid      <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic hold_off(input int unsigned cycles);
    in_bus.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (lanes_due.size() != 0);
  endtask

  // Check outputs before taking the new input, so an early result never meets its own item.
  always @(posedge clk) begin
    lane_set_t predicted;
    lane_set_t oldest;
    logic      moved;
    if (!rst) begin
      moved = 1'b0;
      if (out_bus.valid && out_bus.ready) begin
        moved = 1'b1;
        results_seen++;
        if (lanes_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h %h %h %h", $time,
                   out_bus.lane_zero, out_bus.lane_one, out_bus.lane_two, out_bus.lane_three);
          mismatch_count++;
        end else begin
          oldest = lanes_due.pop_front();
          check_lane("lane_zero",  oldest.lane_zero,  out_bus.lane_zero);
          check_lane("lane_one",   oldest.lane_one,   out_bus.lane_one);
          check_lane("lane_two",   oldest.lane_two,   out_bus.lane_two);
          check_lane("lane_three", oldest.lane_three, out_bus.lane_three);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        moved = 1'b1;
        predicted = absorb_char(in_bus.character, in_bus.word_start);
        if (pinned_lanes.exists(chars_taken)) lanes_due.push_back(pinned_lanes[chars_taken]);
        else lanes_due.push_back(predicted);
        chars_taken++;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver back-pressure: mostly short stalls, a few long, and steady stretches.
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_steady = ($urandom_range(3) == 0);
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_bus.ready <= 1'b0;
    end else if (rx_steady || $urandom_range(99) >= 25) begin
      out_bus.ready <= 1'b1;
    end else begin
      rx_stall_left = pick_gap();
      out_bus.ready <= 1'b0;
    end
  end

  initial begin
    int unsigned random_sent;
    int unsigned run_len;
    int unsigned gap;
    int unsigned kind;
    logic        tx_steady;
    logic        drained_mid;
    clk               = 1'b0;
    rst               = 1'b1;
    in_bus.valid      = 1'b0;
    in_bus.character  = '0;
    in_bus.word_start = 1'b0;
    out_bus.ready     = 1'b0;
    for (int k = 0; k < LANES; k++) lane_st[k] = LANE_RESET[k];
    word_sum       = '0;
    word_prod      = 32'd1;
    word_total     = '0;
    chars_taken    = 0;
    results_seen   = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    chars_sent     = 0;
    rx_stall_left  = 0;
    rx_cycle       = 0;
    rx_steady      = 1'b0;
    random_sent    = 0;
    gap            = 0;
    tx_steady      = 1'b0;
    drained_mid    = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_N; i++) begin
      if (directed_rows[i].pinned) pinned_lanes[chars_sent] = directed_rows[i].lanes;
      send_char(directed_rows[i].ch, directed_rows[i].ws);
      run_len = pick_gap();
      if (run_len > 0) hold_off(run_len);
    end
    drain();

    // Mostly well-formed words, mixed with noise and words missing their start flag.
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent % 100 < 12) tx_steady = ($urandom_range(2) == 0);
      kind = $urandom_range(99);
      if (kind < 70) run_len = $urandom_range(12, 1);
      else if (kind < 90) run_len = 1;
      else run_len = $urandom_range(5, 1);
      for (int j = 0; j < run_len; j++) begin
        if (kind < 70) send_char(pick_char(), j == 0);
        else if (kind < 90) send_char(CHAR_W'($urandom()), 1'($urandom()));
        else send_char(pick_char(), 1'b0);
        random_sent++;
        if (!tx_steady) begin
          gap = pick_gap();
          if (gap > 0) hold_off(gap);
        end
      end
      if (!drained_mid && random_sent >= RANDOM_ITEMS / 2) begin
        drained_mid = 1'b1;
        drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (lanes_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, lanes_due.size());
      mismatch_count += lanes_due.size();
    end
    $display("Sent %0d characters (%0d from the directed table), checked %0d lane results",
             chars_sent, DIRECTED_N, results_seen);
    $display("Covered word starts, empty marks, out-of-range and negative characters; %0d errors",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/flbmh_pkg.sv
sv/flbmh_if.sv
sv/flbmh_ctrl.sv
sv/flbmh_dp.sv
sv/four_lane_byte_mix_hash.sv
tb/sv/testbench.sv
